### hw/rtl/lcd_mode_timing_controller_macros.svh
// Assertion macros used by the checker file.
`ifndef LCD_MODE_TIMING_CONTROLLER_MACROS_SVH
`define LCD_MODE_TIMING_CONTROLLER_MACROS_SVH

// Concurrent check on the rising clock edge, quiet while reset is asserted.
`define LMTC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same check, with the consequent in the cycle after the antecedent.
`define LMTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lmtc_pkg.sv
package lmtc_pkg;

	// LCD mode codes as seen in the STAT mode bits
	typedef enum logic [1:0] {
		MODE_HBLANK   = 2'd0,
		MODE_VBLANK   = 2'd1,
		MODE_OAM_SCAN = 2'd2,
		MODE_TRANSFER = 2'd3
	} mode_t;

	localparam int unsigned CNT_W  = 16;
	localparam int unsigned LINE_W = 8;

endpackage

### hw/rtl/lcd_mode_timing_controller.sv
// Path: a word taken into the input register moves on to the result register once the
//   result slot is free (one input register, one result register).
// Throughput: one word per clock while result_stall is low; with a result waiting under a
//   stall, a word is taken only into an empty input register, and then the input stalls.
// Reset (arst_n low, asynchronous): mode OAM scan, both counters, line and coincidence
//   cleared, both pipeline slots empty.
module lcd_mode_timing_controller #(
	parameter int unsigned HBLANK_CYCLES   = 204,
	parameter int unsigned OAM_CYCLES      = 80,
	parameter int unsigned TRANSFER_CYCLES = 172,
	parameter int unsigned LINE_CYCLES     = 456,
	parameter int unsigned VISIBLE_LINES   = 144,
	parameter int unsigned VBLANK_LINES    = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	// tick channel
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] elapsed_cycles,
	input  logic       lcd_enable,
	input  logic [7:0] line_compare,
	input  logic       hblank_irq_enable,
	input  logic       vblank_stat_enable,
	input  logic       oam_irq_enable,
	input  logic       match_irq_enable,
	// result channel
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] mode,
	output logic [7:0] current_line,
	output logic       coincidence,
	output logic       vblank_request,
	output logic       stat_request,
	output logic       draw_line
);

	localparam int unsigned CW = lmtc_pkg::CNT_W;
	localparam int unsigned LW = lmtc_pkg::LINE_W;

	// Thresholds sized to the counters. The vblank length is cut to the 16-bit counter
	// width; with the default parameters it is 4560 and fits.
	localparam logic [CW-1:0] HB_LEN   = CW'(HBLANK_CYCLES);
	localparam logic [CW-1:0] OAM_LEN  = CW'(OAM_CYCLES);
	localparam logic [CW-1:0] XFER_LEN = CW'(TRANSFER_CYCLES);
	localparam logic [CW-1:0] LINE_LEN = CW'(LINE_CYCLES);
	localparam logic [CW-1:0] VB_LEN   = CW'(LINE_CYCLES * VBLANK_LINES);
	localparam logic [LW-1:0] VIS_LINE  = LW'(VISIBLE_LINES);
	localparam logic [LW-1:0] LAST_LINE = LW'(VISIBLE_LINES + VBLANK_LINES - 1);

	// ------------------------------------------------------------------
	// Input register stage
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] cyc_s1;
	logic       en_s1;
	logic [7:0] cmp_s1;
	logic       hb_en_s1;
	logic       vb_en_s1;
	logic       oam_en_s1;
	logic       match_en_s1;

	// Result slot frees when empty or when its word leaves this cycle.
	logic out_free;
	logic advance;

	assign out_free   = !result_valid || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cyc_s1      <= elapsed_cycles;
			en_s1       <= lcd_enable;
			cmp_s1      <= line_compare;
			hb_en_s1    <= hblank_irq_enable;
			vb_en_s1    <= vblank_stat_enable;
			oam_en_s1   <= oam_irq_enable;
			match_en_s1 <= match_irq_enable;
		end
	end

	// ------------------------------------------------------------------
	// Timing state
	// ------------------------------------------------------------------
	lmtc_pkg::mode_t mode_q, mode_n;
	logic [CW-1:0]   line_cnt_q, line_cnt_n;
	logic [CW-1:0]   vb_cnt_q, vb_cnt_n;
	logic [LW-1:0]   line_q, line_n;
	logic            coin_q, coin_n;
	logic            vreq, sreq, draw;

	logic [CW:0]     sum_wide;
	logic [CW-1:0]   sum_sat;
	logic [CW-1:0]   vb_sum;
	logic [LW-1:0]   line_inc;
	logic [LW-1:0]   vb_line;

	// Line counter saturates; the vblank counter wraps.
	assign sum_wide = {1'b0, line_cnt_q} + {{(CW - 7){1'b0}}, cyc_s1};
	assign sum_sat  = sum_wide[CW] ? {CW{1'b1}} : sum_wide[CW-1:0];
	assign vb_sum   = vb_cnt_q + {{(CW - 8){1'b0}}, cyc_s1};
	assign line_inc = line_q + LW'(1);
	// During vblank the line stops at the last vblank line.
	assign vb_line  = (line_q < LAST_LINE) ? line_inc : line_q;

	always_comb begin
		mode_n     = mode_q;
		line_cnt_n = line_cnt_q;
		vb_cnt_n   = vb_cnt_q;
		line_n     = line_q;
		coin_n     = coin_q;
		vreq       = 1'b0;
		sreq       = 1'b0;
		draw       = 1'b0;
		if (!en_s1) begin
			// LCD off: everything parks, coincidence holds its last value
			mode_n     = lmtc_pkg::MODE_HBLANK;
			line_cnt_n = '0;
			vb_cnt_n   = '0;
			line_n     = '0;
		end else begin
			line_cnt_n = sum_sat;
			unique case (mode_q)
				lmtc_pkg::MODE_HBLANK: begin
					if (sum_sat >= HB_LEN) begin
						line_cnt_n = sum_sat - HB_LEN;
						line_n     = line_inc;
						coin_n     = (line_inc == cmp_s1);
						sreq       = coin_n && match_en_s1;
						if (line_inc == VIS_LINE) begin
							mode_n = lmtc_pkg::MODE_VBLANK;
							vreq   = 1'b1;
							sreq   = sreq || vb_en_s1;
						end else begin
							mode_n = lmtc_pkg::MODE_OAM_SCAN;
							sreq   = sreq || oam_en_s1;
						end
					end
				end
				lmtc_pkg::MODE_VBLANK: begin
					vb_cnt_n = vb_sum;
					// one vblank line elapsed: excess is dropped
					if (vb_sum >= LINE_LEN) begin
						vb_cnt_n = '0;
						line_n   = vb_line;
						coin_n   = (vb_line == cmp_s1);
						sreq     = coin_n && match_en_s1;
					end
					// end of vblank: back to line 0, second compare there
					if (sum_sat >= VB_LEN) begin
						vb_cnt_n   = '0;
						line_cnt_n = '0;
						line_n     = '0;
						coin_n     = (cmp_s1 == '0);
						sreq       = sreq || (coin_n && match_en_s1) || oam_en_s1;
						mode_n     = lmtc_pkg::MODE_OAM_SCAN;
					end
				end
				lmtc_pkg::MODE_OAM_SCAN: begin
					if (sum_sat >= OAM_LEN) begin
						line_cnt_n = sum_sat - OAM_LEN;
						mode_n     = lmtc_pkg::MODE_TRANSFER;
					end
				end
				lmtc_pkg::MODE_TRANSFER: begin
					if (sum_sat >= XFER_LEN) begin
						line_cnt_n = sum_sat - XFER_LEN;
						draw       = 1'b1;
						mode_n     = lmtc_pkg::MODE_HBLANK;
						sreq       = hb_en_s1;
					end
				end
				default: begin
					mode_n = mode_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= lmtc_pkg::MODE_OAM_SCAN;
			line_cnt_q <= '0;
			vb_cnt_q   <= '0;
			line_q     <= '0;
			coin_q     <= 1'b0;
		end else if (advance) begin
			mode_q     <= mode_n;
			line_cnt_q <= line_cnt_n;
			vb_cnt_q   <= vb_cnt_n;
			line_q     <= line_n;
			coin_q     <= coin_n;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode           <= mode_n;
			current_line   <= line_n;
			coincidence    <= coin_n;
			vblank_request <= vreq;
			stat_request   <= sreq;
			draw_line      <= draw;
		end
	end

endmodule

### hw/rtl/lmtc_checker.sv
`include "lcd_mode_timing_controller_macros.svh"

module lmtc_checker #(
	parameter int unsigned VISIBLE_LINES = 144
) (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [1:0] mode,
	input logic [7:0] current_line,
	input logic       vblank_request,
	input logic       draw_line
);

	// a stalled result word holds
	`LMTC_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(mode) && $stable(current_line), "result word changed while stalled")

	// vblank request only on entering vblank at the first vblank line
	`LMTC_ASSERT(a_vreq, result_valid && vblank_request |-> mode == lmtc_pkg::MODE_VBLANK && current_line == 8'(VISIBLE_LINES), "vblank request outside vblank entry")

	// draw pulse only on the move into hblank
	`LMTC_ASSERT(a_draw, result_valid && draw_line |-> mode == lmtc_pkg::MODE_HBLANK && !vblank_request, "draw_line without hblank entry")

endmodule

bind lcd_mode_timing_controller lmtc_checker #(
	.VISIBLE_LINES(VISIBLE_LINES)
) u_lmtc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.mode           (mode),
	.current_line   (current_line),
	.vblank_request (vblank_request),
	.draw_line      (draw_line)
);

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

	// Timing constants, also handed to the block so both sides agree.
	localparam int unsigned HBLANK_CYCLES   = 204;
	localparam int unsigned OAM_CYCLES      = 80;
	localparam int unsigned TRANSFER_CYCLES = 172;
	localparam int unsigned LINE_CYCLES     = 456;
	localparam int unsigned VISIBLE_LINES   = 144;
	localparam int unsigned VBLANK_LINES    = 10;

	localparam int RANDOM_TICKS   = 1090;
	// First stretch of random words keeps the LCD on so at least one full frame runs.
	localparam int FIRST_FRAME    = 700;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	// One tick word as driven on the input channel.
	typedef struct packed {
		logic [7:0] elapsed;
		logic       lcd_on;
		logic [7:0] lyc;
		logic       hb_en;
		logic       vb_en;
		logic       oam_en;
		logic       match_en;
	} tick_t;

	// One status word as expected on the result channel.
	typedef struct packed {
		lmtc_pkg::mode_t mode;
		logic [7:0]      line;
		logic            coin;
		logic            vreq;
		logic            sreq;
		logic            draw;
	} lcd_status_t;

	logic       clk    = 1'b0;
	logic       arst_n = 1'b0;

	logic       item_valid         = 1'b0;
	logic       item_stall;
	logic [7:0] elapsed_cycles     = '0;
	logic       lcd_enable         = 1'b0;
	logic [7:0] line_compare       = '0;
	logic       hblank_irq_enable  = 1'b0;
	logic       vblank_stat_enable = 1'b0;
	logic       oam_irq_enable     = 1'b0;
	logic       match_irq_enable   = 1'b0;

	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [1:0] mode;
	logic [7:0] current_line;
	logic       coincidence;
	logic       vblank_request;
	logic       stat_request;
	logic       draw_line;

	tick_t       pending_ticks[$];
	lcd_status_t expected_status_q[$];

	int error_count = 0;
	int idle_cycles = 0;
	int gap_left    = 0;
	int stall_left  = 0;
	int calm_left[2] = '{0, 0};
	bit item_taken  = 1'b0;

	// Timing state tracked alongside the block.
	lmtc_pkg::mode_t sim_mode     = lmtc_pkg::MODE_OAM_SCAN;
	logic [15:0]     sim_line_cnt = '0;
	logic [15:0]     sim_vbl_cnt  = '0;
	logic [7:0]      sim_line     = '0;
	logic            sim_coin     = 1'b0;

	lcd_mode_timing_controller #(
		.HBLANK_CYCLES  (HBLANK_CYCLES),
		.OAM_CYCLES     (OAM_CYCLES),
		.TRANSFER_CYCLES(TRANSFER_CYCLES),
		.LINE_CYCLES    (LINE_CYCLES),
		.VISIBLE_LINES  (VISIBLE_LINES),
		.VBLANK_LINES   (VBLANK_LINES)
	) uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.elapsed_cycles    (elapsed_cycles),
		.lcd_enable        (lcd_enable),
		.line_compare      (line_compare),
		.hblank_irq_enable (hblank_irq_enable),
		.vblank_stat_enable(vblank_stat_enable),
		.oam_irq_enable    (oam_irq_enable),
		.match_irq_enable  (match_irq_enable),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.mode              (mode),
		.current_line      (current_line),
		.coincidence       (coincidence),
		.vblank_request    (vblank_request),
		.stat_request      (stat_request),
		.draw_line         (draw_line)
	);

	always #1 clk = ~clk;

	// LY/LYC compare: updates the coincidence flag, returns the STAT request it raises.
	function automatic bit line_match(logic [7:0] lyc, logic match_en);
		sim_coin = (sim_line == lyc);
		return sim_coin && match_en;
	endfunction

	// Advance the mode/counter state by one tick word and return the status it yields.
	function automatic lcd_status_t advance_lcd_timing(tick_t t);
		lcd_status_t s;
		logic [16:0] sum;
		s.vreq = 1'b0;
		s.sreq = 1'b0;
		s.draw = 1'b0;
		if (!t.lcd_on) begin
			// LCD off: counters and line clear, coincidence holds
			sim_line_cnt = '0;
			sim_vbl_cnt  = '0;
			sim_line     = '0;
			sim_mode     = lmtc_pkg::MODE_HBLANK;
		end else begin
			sum = sim_line_cnt + t.elapsed;
			sim_line_cnt = sum[16] ? 16'hFFFF : sum[15:0];
			// at most one mode change per tick; outside vblank any excess stays in the counter
			case (sim_mode)
				lmtc_pkg::MODE_HBLANK: begin
					if (sim_line_cnt >= HBLANK_CYCLES) begin
						sim_line_cnt = 16'(sim_line_cnt - HBLANK_CYCLES);
						sim_line = sim_line + 8'd1;
						if (line_match(t.lyc, t.match_en))
							s.sreq = 1'b1;
						if (sim_line == VISIBLE_LINES) begin
							sim_mode = lmtc_pkg::MODE_VBLANK;
							s.vreq = 1'b1;
							if (t.vb_en)
								s.sreq = 1'b1;
						end else begin
							sim_mode = lmtc_pkg::MODE_OAM_SCAN;
							if (t.oam_en)
								s.sreq = 1'b1;
						end
					end
				end
				lmtc_pkg::MODE_VBLANK: begin
					sim_vbl_cnt = sim_vbl_cnt + t.elapsed;
					// line tick inside vblank, excess dropped
					if (sim_vbl_cnt >= LINE_CYCLES) begin
						sim_vbl_cnt = '0;
						if (sim_line < VISIBLE_LINES + VBLANK_LINES - 1)
							sim_line = sim_line + 8'd1;
						if (line_match(t.lyc, t.match_en))
							s.sreq = 1'b1;
					end
					// end of vblank, may follow a line tick in the same word
					if (sim_line_cnt >= LINE_CYCLES * VBLANK_LINES) begin
						sim_vbl_cnt  = '0;
						sim_line_cnt = '0;
						sim_line     = '0;
						if (line_match(t.lyc, t.match_en))
							s.sreq = 1'b1;
						sim_mode = lmtc_pkg::MODE_OAM_SCAN;
						if (t.oam_en)
							s.sreq = 1'b1;
					end
				end
				lmtc_pkg::MODE_OAM_SCAN: begin
					if (sim_line_cnt >= OAM_CYCLES) begin
						sim_line_cnt = 16'(sim_line_cnt - OAM_CYCLES);
						sim_mode = lmtc_pkg::MODE_TRANSFER;
					end
				end
				default: begin
					if (sim_line_cnt >= TRANSFER_CYCLES) begin
						sim_line_cnt = 16'(sim_line_cnt - TRANSFER_CYCLES);
						s.draw = 1'b1;
						sim_mode = lmtc_pkg::MODE_HBLANK;
						if (t.hb_en)
							s.sreq = 1'b1;
					end
				end
			endcase
		end
		s.mode = sim_mode;
		s.line = sim_line;
		s.coin = sim_coin;
		return s;
	endfunction

	// Idle length for one side (0 = sender gap, 1 = receiver stall).
	// Mostly short, a few long, and now and then a calm stretch with none.
	function automatic int idle_length(int side);
		int r;
		if (calm_left[side] != 0) begin
			calm_left[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left[side] = $urandom_range(20, 100);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_error(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic add_tick(int elapsed, bit on, int lyc, bit hb, bit vb, bit oam, bit match_en);
		tick_t t;
		t.elapsed  = elapsed[7:0];
		t.lcd_on   = on;
		t.lyc      = lyc[7:0];
		t.hb_en    = hb;
		t.vb_en    = vb;
		t.oam_en   = oam;
		t.match_en = match_en;
		pending_ticks.push_back(t);
	endtask

	// Driver: new word at the falling edge once the previous one is taken.
	always @(negedge clk) begin : driver
		tick_t t;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (gap_left != 0) begin
				item_valid <= 1'b0;
				gap_left--;
			end else if (pending_ticks.size() != 0) begin
				t = pending_ticks.pop_front();
				item_valid         <= 1'b1;
				elapsed_cycles     <= t.elapsed;
				lcd_enable         <= t.lcd_on;
				line_compare       <= t.lyc;
				hblank_irq_enable  <= t.hb_en;
				vblank_stat_enable <= t.vb_en;
				oam_irq_enable     <= t.oam_en;
				match_irq_enable   <= t.match_en;
				gap_left = idle_length(0);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure, changed at the falling edge.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (stall_left == 0 && $urandom_range(0, 2) == 0)
				stall_left = idle_length(1);
			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Monitor: sample both channels at the rising edge, predict and check, watchdog.
	always @(posedge clk) begin : monitor
		tick_t       t;
		lcd_status_t want;
		bit          word_out;
		if (!arst_n) begin
			item_taken = 1'b0;
		end else begin
			item_taken = item_valid && !item_stall;
			word_out   = result_valid && !result_stall;
			if (word_out) begin
				if (expected_status_q.size() == 0) begin
					report_error("status word with nothing expected");
				end else begin
					want = expected_status_q.pop_front();
					check_field("mode", {6'd0, mode}, {6'd0, want.mode});
					check_field("current_line", current_line, want.line);
					check_field("coincidence", {7'd0, coincidence}, {7'd0, want.coin});
					check_field("vblank_request", {7'd0, vblank_request}, {7'd0, want.vreq});
					check_field("stat_request", {7'd0, stat_request}, {7'd0, want.sreq});
					check_field("draw_line", {7'd0, draw_line}, {7'd0, want.draw});
				end
			end
			if (item_taken) begin
				t.elapsed  = elapsed_cycles;
				t.lcd_on   = lcd_enable;
				t.lyc      = line_compare;
				t.hb_en    = hblank_irq_enable;
				t.vb_en    = vblank_stat_enable;
				t.oam_en   = oam_irq_enable;
				t.match_en = match_irq_enable;
				expected_status_q.push_back(advance_lcd_timing(t));
			end
			idle_cycles = (item_taken || word_out) ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL lcd_mode_timing_controller");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int          r;
		int          elapsed;
		int          lyc;
		int          off_left;
		int          frame_cycles;
		int          est_line;
		bit          on;

		// Directed words, starting from reset: OAM scan, line 0, counters clear.
		add_tick(0,   1, 0,   1, 1, 1, 1);	// no time passes
		add_tick(255, 1, 0,   0, 0, 0, 0);	// OAM -> transfer, excess kept
		add_tick(0,   1, 255, 1, 0, 0, 0);	// excess alone ends transfer: draw + HBlank STAT
		add_tick(255, 1, 1,   0, 0, 1, 1);	// HBlank -> line 1, compare match + OAM STAT
		add_tick(26,  1, 1,   1, 1, 1, 1);	// exactly at OAM threshold
		add_tick(171, 1, 0,   1, 1, 1, 1);	// one short of transfer end
		add_tick(1,   1, 0,   1, 0, 0, 0);	// transfer ends exactly
		add_tick(203, 1, 2,   0, 0, 0, 1);	// one short of HBlank end
		add_tick(1,   1, 2,   0, 0, 0, 0);	// line 2 matches, match STAT off
		add_tick(0,   0, 255, 1, 1, 1, 1);	// LCD off, coincidence holds
		add_tick(255, 0, 0,   1, 1, 1, 1);	// still off, cycles ignored
		add_tick(204, 1, 0,   1, 1, 1, 1);	// restart in HBlank, line 1, no match
		add_tick(255, 1, 255, 1, 1, 1, 1);
		add_tick(255, 1, 255, 0, 0, 0, 0);
		add_tick(255, 1, 2,   1, 1, 1, 1);	// line 2 compare
		add_tick(170, 1, 170, 0, 1, 0, 1);
		add_tick(85,  1, 85,  1, 0, 1, 0);
		add_tick(0,   0, 0,   0, 0, 0, 0);	// off again, line 0

		// Random words. Line compare mostly tracks a rough estimate of the line so that
		// matches occur often; the LCD goes off only in short bursts after the first frame.
		off_left     = 0;
		frame_cycles = 0;
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				elapsed = 0;
			else if (r < 25)
				elapsed = $urandom_range(1, 16);
			else if (r < 55)
				elapsed = $urandom_range(180, 255);
			else
				elapsed = $urandom_range(0, 255);

			if (off_left != 0) begin
				on = 1'b0;
				off_left--;
			end else if (n >= FIRST_FRAME && $urandom_range(0, 99) == 0) begin
				on = 1'b0;
				off_left = $urandom_range(0, 3);
			end else begin
				on = 1'b1;
			end

			est_line = (frame_cycles / LINE_CYCLES) % (VISIBLE_LINES + VBLANK_LINES);
			r = $urandom_range(0, 99);
			if (r < 60)
				lyc = est_line + $urandom_range(0, 1);
			else if (r < 75)
				lyc = $urandom_range(0, 1) ? 255 : 0;
			else
				lyc = $urandom_range(0, 255);

			frame_cycles = on ? frame_cycles + elapsed : 0;
			add_tick(elapsed, on, lyc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: all words sent and every status word returned.
		while (pending_ticks.size() != 0 || item_valid || expected_status_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (expected_status_q.size() != 0)
			report_error("status words still expected at end of run");
		if (error_count == 0)
			$display("PASS lcd_mode_timing_controller");
		else
			$display("FAIL lcd_mode_timing_controller");
		$finish;
	end

endmodule

### lcd_mode_timing_controller.f
+incdir+hw/rtl
hw/rtl/lmtc_pkg.sv
hw/rtl/lcd_mode_timing_controller.sv
hw/rtl/lmtc_checker.sv
sim/tb.sv
